// ----- design/gps_pkg.sv -----
// ----------------------------------------------------------------------------
// gps_pkg
// Shared widths, constants, codes and types of the go-to-point steering block.
// ----------------------------------------------------------------------------
package gps_pkg;

	// Operand widths.
	localparam int POS_BITS        = 20;
	localparam int DIFF_BITS       = POS_BITS + 1;
	localparam int SQ_BITS         = 2 * DIFF_BITS;
	localparam int TOL_BITS        = 20;
	localparam int TOL_SQ_BITS     = 2 * TOL_BITS;
	localparam int ROOT_BITS       = DIFF_BITS;
	localparam int REM_BITS        = ROOT_BITS + 2;
	localparam int HEAD_BITS       = 15;
	localparam int ANGLE_FRAC_BITS = 12;

	// CORDIC datapath.
	localparam int CORDIC_STEPS = 31;
	localparam int CX_BITS      = DIFF_BITS + 3;
	localparam int Z_BITS       = 34;
	localparam int ROUND_SH     = 30 - ANGLE_FRAC_BITS;
	localparam int ANG_BITS     = Z_BITS - ROUND_SH;
	localparam int ERR_BITS     = ANG_BITS + 1;

	localparam logic signed [Z_BITS-1:0]   PI_Q30 = 34'sd3373259426;
	localparam logic signed [ERR_BITS-1:0] PI_F   = 17'sd12868;
	localparam logic signed [ERR_BITS-1:0] TWO_PI_F = 17'sd25736;

	// Arctangent table, radians scaled by 2^30, truncated.
	localparam logic [Z_BITS-1:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
		34'h03243F6A8, 34'h01DAC6705, 34'h00FADBAFC, 34'h007F56EA6, 34'h003FEAB76,
		34'h001FFD55B, 34'h000FFFAAA, 34'h0007FFF55, 34'h0003FFFEA, 34'h0001FFFFD,
		34'h0000FFFFF, 34'h00007FFFF, 34'h00003FFFF, 34'h00001FFFF, 34'h00000FFFF,
		34'h000007FFF, 34'h000003FFF, 34'h000001FFF, 34'h000000FFF, 34'h0000007FF,
		34'h0000003FF, 34'h0000001FF, 34'h0000000FF, 34'h00000007F, 34'h00000003F,
		34'h00000001F, 34'h00000000F, 34'h000000007, 34'h000000003, 34'h000000001,
		34'h000000000
	};

	// Speed limits.
	localparam int SPD_BITS = 11;
	localparam logic [14:0] TURN_MIN  = 15'd30;
	localparam logic [14:0] TURN_MAX  = 15'd250;
	localparam logic [24:0] DRIVE_MIN = 25'd75;
	localparam logic [24:0] DRIVE_MAX = 25'd1000;

	// Action codes.
	localparam logic [1:0] ACT_STOP  = 2'd0;
	localparam logic [1:0] ACT_TURN  = 2'd1;
	localparam logic [1:0] ACT_DRIVE = 2'd2;

	// Register indexes.
	localparam logic [1:0] REG_GAIN_D = 2'd0;
	localparam logic [1:0] REG_GAIN_H = 2'd1;
	localparam logic [1:0] REG_TOL_D  = 2'd2;
	localparam logic [1:0] REG_TOL_H  = 2'd3;

	// Queue depth.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	// Classified item handed from the front end to the back end.
	typedef struct packed {
		logic signed [CX_BITS-1:0]   x;
		logic signed [CX_BITS-1:0]   y;
		logic signed [Z_BITS-1:0]    z;
		logic [SQ_BITS-1:0]          sq;
		logic                        zero;
		logic                        arrive;
		logic signed [HEAD_BITS-1:0] heading;
	} gps_item_t;

endpackage

// ----- design/gps_front.sv -----
// ----------------------------------------------------------------------------
// gps_front
// Accepts poses, forms the offset, squared distance, arrival flag and the
// half-plane pre-rotation for the CORDIC, and pushes them into the queue.
// ----------------------------------------------------------------------------
module gps_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [gps_pkg::POS_BITS-1:0] robot_x,
	input  logic signed [gps_pkg::POS_BITS-1:0] robot_y,
	input  logic signed [gps_pkg::HEAD_BITS-1:0] robot_heading,
	input  logic signed [gps_pkg::POS_BITS-1:0] goal_x,
	input  logic signed [gps_pkg::POS_BITS-1:0] goal_y,
	input  logic [gps_pkg::TOL_SQ_BITS-1:0]     tol_sq,
	input  logic                                q_full,
	output logic                                push,
	output gps_pkg::gps_item_t                  push_item
);
	import gps_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [DIFF_BITS-1:0] dx_s1, dy_s1;
	logic signed [HEAD_BITS-1:0] hd_s1, hd_s2;
	logic [SQ_BITS-1:0] sqx_s2, sqy_s2;
	logic signed [CX_BITS-1:0] x_s2, y_s2;
	logic signed [Z_BITS-1:0] z_s2;
	logic zero_s2;
	logic [DIFF_BITS-1:0] ax, ay;
	logic [SQ_BITS-1:0] sum;
	gps_item_t item_s3;

	// The front end advances unless its last stage is blocked by a full queue.
	assign en       = !v_s3 || !q_full;
	assign in_ready = en;
	assign push     = v_s3 && !q_full;
	assign push_item = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: offset to the goal.
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DIFF_BITS'(goal_x) - DIFF_BITS'(robot_x);
			dy_s1 <= DIFF_BITS'(goal_y) - DIFF_BITS'(robot_y);
			hd_s1 <= robot_heading;
		end
	end

	// Stage 2: squares and the rotation by pi for the left half-plane.
	assign ax = dx_s1[DIFF_BITS-1] ? DIFF_BITS'(-dx_s1) : DIFF_BITS'(dx_s1);
	assign ay = dy_s1[DIFF_BITS-1] ? DIFF_BITS'(-dy_s1) : DIFF_BITS'(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= SQ_BITS'(ax) * SQ_BITS'(ax);
			sqy_s2  <= SQ_BITS'(ay) * SQ_BITS'(ay);
			hd_s2   <= hd_s1;
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			if (dx_s1[DIFF_BITS-1]) begin
				x_s2 <= -CX_BITS'(dx_s1);
				y_s2 <= -CX_BITS'(dy_s1);
				z_s2 <= dy_s1[DIFF_BITS-1] ? -PI_Q30 : PI_Q30;
			end else begin
				x_s2 <= CX_BITS'(dx_s1);
				y_s2 <= CX_BITS'(dy_s1);
				z_s2 <= '0;
			end
		end
	end

	// Stage 3: squared distance and the arrival test.
	assign sum = sqx_s2 + sqy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3.x       <= x_s2;
			item_s3.y       <= y_s2;
			item_s3.z       <= z_s2;
			item_s3.sq      <= sum;
			item_s3.zero    <= zero_s2;
			item_s3.arrive  <= sum <= SQ_BITS'(tol_sq);
			item_s3.heading <= hd_s2;
		end
	end

endmodule

// ----- design/gps_queue.sv -----
// ----------------------------------------------------------------------------
// gps_queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module gps_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gps_pkg::gps_item_t push_item,
	input  logic               pop,
	output gps_pkg::gps_item_t head,
	output logic               empty,
	output logic               full
);
	import gps_pkg::*;

	gps_item_t mem_q [0:Q_DEPTH-1];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0] cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign head  = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");

endmodule

// ----- design/gps_back.sv -----
// ----------------------------------------------------------------------------
// gps_back
// Runs the square root and CORDIC pipelines side by side, wraps the heading
// error, applies the gains and limits, and holds the result register.
// ----------------------------------------------------------------------------
module gps_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gps_pkg::gps_item_t                    head,
	input  logic                                  empty,
	output logic                                  pop,
	input  logic [15:0]                           gain_distance,
	input  logic [11:0]                           gain_heading,
	input  logic [13:0]                           heading_tolerance,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [gps_pkg::SPD_BITS-1:0]   left_speed,
	output logic signed [gps_pkg::SPD_BITS-1:0]   right_speed,
	output logic [1:0]                            action,
	output logic [gps_pkg::ROOT_BITS-1:0]         distance_error,
	output logic signed [gps_pkg::HEAD_BITS-1:0]  heading_error
);
	import gps_pkg::*;

	localparam int NS = CORDIC_STEPS;

	logic en;
	logic                        v    [0:NS];
	logic signed [CX_BITS-1:0]   cx   [0:NS];
	logic signed [CX_BITS-1:0]   cy   [0:NS];
	logic signed [Z_BITS-1:0]    cz   [0:NS];
	logic [SQ_BITS-1:0]          rad  [0:NS];
	logic [ROOT_BITS-1:0]        root [0:NS];
	logic [REM_BITS-1:0]         rem  [0:NS];
	logic                        zero [0:NS];
	logic                        arr  [0:NS];
	logic signed [HEAD_BITS-1:0] hd   [0:NS];

	logic v_s32, v_s33;
	logic signed [HEAD_BITS-1:0] err_s32, err_s33;
	logic [ROOT_BITS-1:0] dist_s32, dist_s33;
	logic arr_s32, arr_s33, turn_s33;
	logic signed [27:0] p_s33;
	logic [36:0] s_s33;
	logic out_valid_q;

	logic signed [ANG_BITS-1:0] ang;
	logic signed [ERR_BITS-1:0] raw_err, wrap_err;
	logic [HEAD_BITS-1:0] abs_err;
	logic [27:0] abs_p;
	logic [14:0] mag, mag_c;
	logic [24:0] spd, spd_c;

	// The whole back end moves together whenever the result register is free.
	assign en        = !out_valid_q || out_ready;
	assign pop       = en && !empty;
	assign out_valid = out_valid_q;

	// Stage zero is the queue head.
	assign v[0]    = !empty;
	assign cx[0]   = head.x;
	assign cy[0]   = head.y;
	assign cz[0]   = head.z;
	assign rad[0]  = head.sq;
	assign root[0] = '0;
	assign rem[0]  = '0;
	assign zero[0] = head.zero;
	assign arr[0]  = head.arrive;
	assign hd[0]   = head.heading;

	// One CORDIC micro-rotation and, in the first stages, one root digit per stage.
	for (genvar i = 0; i < NS; i++) begin : g_stage
		localparam int PAIR_LSB = (i < ROOT_BITS) ? 2 * (ROOT_BITS - 1 - i) : 0;
		logic [REM_BITS+1:0] rem_sh, trial;
		assign rem_sh = {rem[i], (i < ROOT_BITS) ? rad[i][PAIR_LSB +: 2] : 2'b00};
		assign trial  = (REM_BITS+2)'({root[i], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[i+1] <= 1'b0;
			end else if (en) begin
				v[i+1] <= v[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy[i][CX_BITS-1]) begin
					cx[i+1] <= cx[i] + (cy[i] >>> i);
					cy[i+1] <= cy[i] - (cx[i] >>> i);
					cz[i+1] <= cz[i] + $signed(ATAN_Q30[i]);
				end else begin
					cx[i+1] <= cx[i] - (cy[i] >>> i);
					cy[i+1] <= cy[i] + (cx[i] >>> i);
					cz[i+1] <= cz[i] - $signed(ATAN_Q30[i]);
				end
				if (i < ROOT_BITS) begin
					if (rem_sh >= trial) begin
						rem[i+1]  <= REM_BITS'(rem_sh - trial);
						root[i+1] <= {root[i][ROOT_BITS-2:0], 1'b1};
					end else begin
						rem[i+1]  <= REM_BITS'(rem_sh);
						root[i+1] <= {root[i][ROOT_BITS-2:0], 1'b0};
					end
				end else begin
					rem[i+1]  <= rem[i];
					root[i+1] <= root[i];
				end
				rad[i+1]  <= rad[i];
				zero[i+1] <= zero[i];
				arr[i+1]  <= arr[i];
				hd[i+1]   <= hd[i];
			end
		end
	end

	// Round the angle and wrap the heading error into (-pi, pi].
	assign ang = zero[NS] ? '0
		: ANG_BITS'((cz[NS] + Z_BITS'(1 <<< (ROUND_SH - 1))) >>> ROUND_SH);
	assign raw_err = ERR_BITS'(ang) - ERR_BITS'(hd[NS]);

	always_comb begin
		priority if (raw_err > PI_F) begin
			wrap_err = raw_err - TWO_PI_F;
		end else if (raw_err <= -PI_F) begin
			wrap_err = raw_err + TWO_PI_F;
		end else begin
			wrap_err = raw_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s32       <= 1'b0;
			v_s33       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s32       <= v[NS];
			v_s33       <= v_s32;
			out_valid_q <= v_s33;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s32  <= HEAD_BITS'(wrap_err);
			dist_s32 <= root[NS];
			arr_s32  <= arr[NS];
		end
	end

	// Gain products and the turn decision.
	assign abs_err = err_s32[HEAD_BITS-1] ? HEAD_BITS'(-err_s32) : HEAD_BITS'(err_s32);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s33    <= $signed({1'b0, gain_heading}) * err_s32;
			s_s33    <= 37'(gain_distance) * 37'(dist_s32);
			turn_s33 <= abs_err > HEAD_BITS'(heading_tolerance);
			err_s33  <= err_s32;
			dist_s33 <= dist_s32;
			arr_s33  <= arr_s32;
		end
	end

	// Limits and the wheel commands.
	assign abs_p = p_s33[27] ? 28'(-p_s33) : 28'(p_s33);
	assign mag   = 15'(abs_p >> ANGLE_FRAC_BITS);
	assign mag_c = (mag > TURN_MAX) ? TURN_MAX : ((mag < TURN_MIN) ? TURN_MIN : mag);
	assign spd   = 25'(s_s33 >> 12);
	assign spd_c = (spd > DRIVE_MAX) ? DRIVE_MAX : ((spd < DRIVE_MIN) ? DRIVE_MIN : spd);

	always_ff @(posedge clk) begin
		if (en) begin
			distance_error <= dist_s33;
			heading_error  <= err_s33;
			priority if (arr_s33) begin
				action      <= ACT_STOP;
				left_speed  <= '0;
				right_speed <= '0;
			end else if (turn_s33) begin
				action <= ACT_TURN;
				if (p_s33 == '0) begin
					left_speed  <= '0;
					right_speed <= '0;
				end else if (p_s33[27]) begin
					left_speed  <= SPD_BITS'(mag_c);
					right_speed <= -SPD_BITS'(mag_c);
				end else begin
					left_speed  <= -SPD_BITS'(mag_c);
					right_speed <= SPD_BITS'(mag_c);
				end
			end else begin
				action      <= ACT_DRIVE;
				left_speed  <= SPD_BITS'(spd_c);
				right_speed <= SPD_BITS'(spd_c);
			end
		end
	end

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && action == ACT_STOP |-> left_speed == '0 && right_speed == '0)
		else $error("stop result with nonzero speed");
	a_drive_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && action == ACT_DRIVE |-> left_speed == right_speed)
		else $error("drive result with unequal wheels");
	a_turn_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && action == ACT_TURN |-> left_speed == -right_speed)
		else $error("turn result with wheels not opposite");

endmodule

// ----- design/goto_point_steering.sv -----
// ----------------------------------------------------------------------------
// goto_point_steering
// Go-to-goal proportional steering: distance, heading error and wheel speeds.
// ----------------------------------------------------------------------------
// Usage:
// A pose transaction (robot_x, robot_y, robot_heading, goal_x, goal_y) is
// accepted when in_valid and in_ready are high at a clock edge. Each one
// produces exactly one result transaction (left_speed, right_speed, action,
// distance_error, heading_error), taken when out_valid and out_ready are high.
// Each pose passes three front stages, one queue slot, 31 CORDIC stages holding
// the 21 square root digit steps, two stages for the error wrap and the gain
// multipliers, and the result register. A four-entry queue separates the front
// and back ends. Throughput is one transaction per cycle until the receiver
// stalls; then the back end holds, the queue fills and in_ready drops. The
// configuration registers sit on an APB port and must be written only while
// no transaction is in flight, which the block does not enforce. Reset empties
// all pipelines and the queue and loads the register defaults.
// ----------------------------------------------------------------------------
module goto_point_steering (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [3:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [gps_pkg::POS_BITS-1:0]   robot_x,
	input  logic signed [gps_pkg::POS_BITS-1:0]   robot_y,
	input  logic signed [gps_pkg::HEAD_BITS-1:0]  robot_heading,
	input  logic signed [gps_pkg::POS_BITS-1:0]   goal_x,
	input  logic signed [gps_pkg::POS_BITS-1:0]   goal_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [gps_pkg::SPD_BITS-1:0]   left_speed,
	output logic signed [gps_pkg::SPD_BITS-1:0]   right_speed,
	output logic [1:0]                            action,
	output logic [gps_pkg::ROOT_BITS-1:0]         distance_error,
	output logic signed [gps_pkg::HEAD_BITS-1:0]  heading_error
);
	import gps_pkg::*;

	logic [15:0] gain_d_q;
	logic [11:0] gain_h_q;
	logic [TOL_BITS-1:0] tol_d_q;
	logic [13:0] tol_h_q;
	logic [TOL_SQ_BITS-1:0] tol_sq_q;
	logic wr;
	logic push, pop, q_empty, q_full;
	gps_item_t push_item, head;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_d_q <= 16'd2560;
			gain_h_q <= 12'd500;
			tol_d_q  <= 20'd480;
			tol_h_q  <= 14'd536;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_GAIN_D: gain_d_q <= pwdata[15:0];
				REG_GAIN_H: gain_h_q <= pwdata[11:0];
				REG_TOL_D:  tol_d_q  <= pwdata[TOL_BITS-1:0];
				REG_TOL_H:  tol_h_q  <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	// Squared arrival radius, registered from tol_d_q in the cycle after a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_sq_q <= TOL_SQ_BITS'(230400);
		end else begin
			tol_sq_q <= TOL_SQ_BITS'(tol_d_q) * TOL_SQ_BITS'(tol_d_q);
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[3:2])
			REG_GAIN_D: prdata = 32'(gain_d_q);
			REG_GAIN_H: prdata = 32'(gain_h_q);
			REG_TOL_D:  prdata = 32'(tol_d_q);
			REG_TOL_H:  prdata = 32'(tol_h_q);
			default:    prdata = '0;
		endcase
	end

	gps_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.robot_x       (robot_x),
		.robot_y       (robot_y),
		.robot_heading (robot_heading),
		.goal_x        (goal_x),
		.goal_y        (goal_y),
		.tol_sq        (tol_sq_q),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	gps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	gps_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head              (head),
		.empty             (q_empty),
		.pop               (pop),
		.gain_distance     (gain_d_q),
		.gain_heading      (gain_h_q),
		.heading_tolerance (tol_h_q),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.left_speed        (left_speed),
		.right_speed       (right_speed),
		.action            (action),
		.distance_error    (distance_error),
		.heading_error     (heading_error)
	);

endmodule
